// ===== design/trz_pkg.sv =====
// Shared types, sizes and helpers of the triangle rasterizer with depth store.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package trz_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int DEPTH_BITS = 16;

   localparam int CFG_W   = 10;
   localparam int PIX_W   = 9;
   localparam int COLOR_W = 24;
   localparam int COORD_W = 16;
   localparam int ZIN_W   = 16;

   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int BOX_W      = ((DIM_W + 1 > 13) ? DIM_W + 1 : 13) + 1;

   localparam int XY_W    = (X_W > Y_W) ? X_W : Y_W;
   localparam int CW      = XY_W + 5;
   localparam int DIFF_W  = ((CW > COORD_W) ? CW : COORD_W) + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int EDGE_W  = PROD_W + 1;
   localparam int MUL_W   = EDGE_W - 1 + ZIN_W;
   localparam int REM_A   = MUL_W + 3;
   localparam int REM_B   = EDGE_W + DEPTH_BITS;
   localparam int REM_W   = (REM_A > REM_B) ? REM_A : REM_B;
   localparam int BIT_W   = $clog2(DEPTH_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DEPTH_BITS-1:0] FAR_DEPTH = '1;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_STEP  = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      JOB_CLEAR,
      JOB_LOAD,
      JOB_STEP,
      JOB_DEAD,
      JOB_NOP
   } job_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_AREA_MUL,
      ST_AREA_SUB,
      ST_EDGE_MUL,
      ST_EDGE_SUB,
      ST_DEPTH_MUL,
      ST_SUM,
      ST_ROUND,
      ST_SAT,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [1:0]                func;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic [ZIN_W-1:0]          adepth;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic [ZIN_W-1:0]          bdepth;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic [ZIN_W-1:0]          cdepth;
      logic [COLOR_W-1:0]        tri_color;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pix_x;
      logic [PIX_W-1:0]   pix_y;
      logic [COLOR_W-1:0] pix_color;
      logic               pix_write;
      logic               scan_done;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
   } dims_type;

   typedef struct packed {
      job_type        job;
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic           last;
      req_type        req;
   } task_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                input logic [DIM_W-1:0] maxv);
      logic [DIM_W+CFG_W-1:0] vw;
      logic [DIM_W+CFG_W-1:0] mw;
      vw = (DIM_W+CFG_W)'(v);
      mw = (DIM_W+CFG_W)'(maxv);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (vw > mw) begin
         return maxv;
      end else begin
         return DIM_W'(v);
      end
   endfunction

endpackage
`default_nettype wire

// ===== design/trz_queue.sv =====
// Two-entry task queue between the front and the back of the rasterizer.
// Depends on trz_pkg for the task type and depth.
`timescale 1ns / 1ps
`default_nettype none
module trz_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire trz_pkg::task_type push_data,
   input  wire logic              pop,
   output trz_pkg::task_type      pop_data,
   output logic                   empty,
   output logic                   full
);

   trz_pkg::task_type                 mem_ff [trz_pkg::QUEUE_DEPTH];
   logic [trz_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [trz_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [trz_pkg::QCNT_W-1:0]        count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == trz_pkg::QCNT_W'(trz_pkg::QUEUE_DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == trz_pkg::QPTR_W'(trz_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == trz_pkg::QPTR_W'(trz_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/trz_front.sv =====
// Front of the rasterizer: decodes accepted items, keeps the bounding box and
// the scan position, and queues one task per item. Depends on trz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trz_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire trz_pkg::req_type   req_data,
   input  wire trz_pkg::dims_type  dims,
   output logic                    push,
   output trz_pkg::task_type       push_data
);

   logic [trz_pkg::X_W-1:0] x0_ff, x0_in, x1_ff, x1_in, sx_ff, sx_in;
   logic [trz_pkg::Y_W-1:0] y0_ff, y0_in, y1_ff, y1_in, sy_ff, sy_in;
   logic                    live_ff, live_in;

   logic signed [trz_pkg::COORD_W-1:0] min_x, max_x, min_y, max_y;
   logic signed [trz_pkg::COORD_W:0]   up_x, up_y;
   logic signed [trz_pkg::BOX_W-1:0]   lo_x, hi_x, lo_y, hi_y, lim_x, lim_y;
   logic                               last;

   always_comb begin
      min_x = req_data.ax;
      max_x = req_data.ax;
      if (req_data.bx < min_x) min_x = req_data.bx;
      if (req_data.cx < min_x) min_x = req_data.cx;
      if (req_data.bx > max_x) max_x = req_data.bx;
      if (req_data.cx > max_x) max_x = req_data.cx;
      min_y = req_data.ay;
      max_y = req_data.ay;
      if (req_data.by < min_y) min_y = req_data.by;
      if (req_data.cy < min_y) min_y = req_data.cy;
      if (req_data.by > max_y) max_y = req_data.by;
      if (req_data.cy > max_y) max_y = req_data.cy;

      up_x  = $signed({max_x[trz_pkg::COORD_W-1], max_x}) + 17'sd15;
      up_y  = $signed({max_y[trz_pkg::COORD_W-1], max_y}) + 17'sd15;
      lim_x = $signed(trz_pkg::BOX_W'(dims.w)) - trz_pkg::BOX_W'(1);
      lim_y = $signed(trz_pkg::BOX_W'(dims.h)) - trz_pkg::BOX_W'(1);

      lo_x = trz_pkg::BOX_W'($signed(min_x[trz_pkg::COORD_W-1:4]));
      lo_y = trz_pkg::BOX_W'($signed(min_y[trz_pkg::COORD_W-1:4]));
      hi_x = trz_pkg::BOX_W'($signed(up_x[trz_pkg::COORD_W:4]));
      hi_y = trz_pkg::BOX_W'($signed(up_y[trz_pkg::COORD_W:4]));
      if (lo_x < 0) lo_x = '0;
      if (lo_y < 0) lo_y = '0;
      if (hi_x > lim_x) hi_x = lim_x;
      if (hi_y > lim_y) hi_y = lim_y;
   end

   always_comb begin
      x0_in   = x0_ff;
      x1_in   = x1_ff;
      y0_in   = y0_ff;
      y1_in   = y1_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      live_in = live_ff;
      last    = (sx_ff == x1_ff) && (sy_ff == y1_ff);

      push           = accept;
      push_data.job  = trz_pkg::JOB_NOP;
      push_data.x    = '0;
      push_data.y    = '0;
      push_data.last = 1'b0;
      push_data.req  = req_data;

      case (req_data.func)
         trz_pkg::FUNC_CLEAR: begin
            push_data.job = trz_pkg::JOB_CLEAR;
         end
         trz_pkg::FUNC_LOAD: begin
            push_data.job = trz_pkg::JOB_LOAD;
            if (accept) begin
               x0_in   = trz_pkg::X_W'(lo_x);
               x1_in   = trz_pkg::X_W'(hi_x);
               y0_in   = trz_pkg::Y_W'(lo_y);
               y1_in   = trz_pkg::Y_W'(hi_y);
               sx_in   = trz_pkg::X_W'(lo_x);
               sy_in   = trz_pkg::Y_W'(lo_y);
               live_in = (lo_x <= hi_x) && (lo_y <= hi_y);
            end
         end
         trz_pkg::FUNC_STEP: begin
            if (live_ff) begin
               push_data.job  = trz_pkg::JOB_STEP;
               push_data.x    = sx_ff;
               push_data.y    = sy_ff;
               push_data.last = last;
               if (accept) begin
                  if (last) begin
                     live_in = 1'b0;
                  end else if (sy_ff < y1_ff) begin
                     sy_in = sy_ff + 1'b1;
                  end else begin
                     sy_in = y0_ff;
                     sx_in = sx_ff + 1'b1;
                  end
               end
            end else begin
               push_data.job = trz_pkg::JOB_DEAD;
            end
         end
         default: begin
            push_data.job = trz_pkg::JOB_NOP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff   <= '0;
         x1_ff   <= '0;
         y0_ff   <= '0;
         y1_ff   <= '0;
         sx_ff   <= '0;
         sy_ff   <= '0;
         live_ff <= 1'b0;
      end else begin
         x0_ff   <= x0_in;
         x1_ff   <= x1_in;
         y0_ff   <= y0_in;
         y1_ff   <= y1_in;
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         live_ff <= live_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/trz_back.sv =====
// Back of the rasterizer: triangle setup, edge tests, depth interpolation with
// an iterative divider, and the depth store with its clearing pass. Uses trz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module trz_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire trz_pkg::dims_type  dims,
   input  wire trz_pkg::task_type  task_data,
   input  wire logic               task_empty,
   output logic                    task_pop,
   output logic                    init_busy,
   output logic                    rsp_strobe,
   output trz_pkg::rsp_type        rsp_data
);

   trz_pkg::state_type state_ff, state_in;
   trz_pkg::task_type  job_ff;
   trz_pkg::req_type   tri_ff;

   logic signed [trz_pkg::EDGE_W-1:0] area_ff;
   logic signed [trz_pkg::PROD_W-1:0] prod_ff [6];
   logic signed [trz_pkg::EDGE_W-1:0] edge_ff [3];
   logic [trz_pkg::MUL_W-1:0]         mul_ff [3];
   logic [trz_pkg::ADDR_W-1:0]        addr_ff, cnt_ff;
   logic [trz_pkg::REM_W-1:0]         num_ff, rem_ff, dsh_ff;
   logic [trz_pkg::DEPTH_BITS-1:0]    quo_ff, rd_data_ff;
   logic [trz_pkg::BIT_W-1:0]         bit_ff;
   logic                              ok_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   trz_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [trz_pkg::DEPTH_BITS-1:0] mem [trz_pkg::STORE_SIZE];
   logic                           mem_we;
   logic [trz_pkg::ADDR_W-1:0]     mem_addr;
   logic [trz_pkg::DEPTH_BITS-1:0] mem_wdata;

   logic signed [trz_pkg::DIFF_W-1:0] vax, vay, vbx, vby, vcx, vcy, ppx, ppy;
   logic signed [trz_pkg::DIFF_W-1:0] opa [6];
   logic signed [trz_pkg::DIFF_W-1:0] opb [6];
   logic [trz_pkg::EDGE_W-2:0]        area_u;
   logic [trz_pkg::DIM_W-1:0]         row;
   logic                              covered, sat, wr, cnt_last, div_last;

   assign vax = trz_pkg::DIFF_W'(tri_ff.ax);
   assign vay = trz_pkg::DIFF_W'(tri_ff.ay);
   assign vbx = trz_pkg::DIFF_W'(tri_ff.bx);
   assign vby = trz_pkg::DIFF_W'(tri_ff.by);
   assign vcx = trz_pkg::DIFF_W'(tri_ff.cx);
   assign vcy = trz_pkg::DIFF_W'(tri_ff.cy);
   assign ppx = trz_pkg::DIFF_W'($signed({1'b0, job_ff.x, 4'b1000}));
   assign ppy = trz_pkg::DIFF_W'($signed({1'b0, job_ff.y, 4'b1000}));
   assign area_u = area_ff[trz_pkg::EDGE_W-2:0];
   assign row = dims.h - 1'b1 - trz_pkg::DIM_W'(job_ff.y);

   assign covered = !edge_ff[0][trz_pkg::EDGE_W-1] && !edge_ff[1][trz_pkg::EDGE_W-1] &&
                    !edge_ff[2][trz_pkg::EDGE_W-1] && (area_ff > 0) &&
                    (trz_pkg::DIM_W'(job_ff.x) < dims.w) &&
                    (trz_pkg::DIM_W'(job_ff.y) < dims.h);
   assign sat = rem_ff >= (trz_pkg::REM_W'(area_u) << trz_pkg::DEPTH_BITS);
   assign wr = ok_ff && (rd_data_ff > quo_ff);
   assign cnt_last = (cnt_ff == trz_pkg::ADDR_W'(trz_pkg::STORE_SIZE - 1));
   assign div_last = (bit_ff == trz_pkg::BIT_W'(trz_pkg::DEPTH_BITS - 1));

   always_comb begin
      opa[0] = vax - vbx;  opb[0] = vay - ppy;
      opa[1] = vay - vby;  opb[1] = vax - ppx;
      opa[2] = vbx - vcx;  opb[2] = vby - ppy;
      opa[3] = vby - vcy;  opb[3] = vbx - ppx;
      opa[4] = vcx - vax;  opb[4] = vcy - ppy;
      opa[5] = vcy - vay;  opb[5] = vcx - ppx;
      if (state_ff == trz_pkg::ST_AREA_MUL) begin
         opa[0] = vbx - vcx;  opb[0] = vby - vay;
         opa[1] = vby - vcy;  opb[1] = vbx - vax;
      end
   end

   always_comb begin
      state_in     = state_ff;
      task_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = addr_ff;
      mem_wdata    = quo_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         trz_pkg::ST_INIT: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = trz_pkg::FAR_DEPTH;
            if (cnt_last) state_in = trz_pkg::ST_IDLE;
         end
         trz_pkg::ST_IDLE: begin
            if (!task_empty) begin
               task_pop = 1'b1;
               case (task_data.job)
                  trz_pkg::JOB_CLEAR: state_in = trz_pkg::ST_CLEAR;
                  trz_pkg::JOB_LOAD:  state_in = trz_pkg::ST_AREA_MUL;
                  trz_pkg::JOB_STEP:  state_in = trz_pkg::ST_EDGE_MUL;
                  trz_pkg::JOB_DEAD: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.scan_done = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         trz_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = cnt_ff;
            mem_wdata = trz_pkg::FAR_DEPTH;
            if (cnt_last) begin
               state_in         = trz_pkg::ST_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in.scan_done = 1'b1;
            end
         end
         trz_pkg::ST_AREA_MUL: state_in = trz_pkg::ST_AREA_SUB;
         trz_pkg::ST_AREA_SUB: begin
            state_in         = trz_pkg::ST_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_in.scan_done = 1'b1;
         end
         trz_pkg::ST_EDGE_MUL: state_in = trz_pkg::ST_EDGE_SUB;
         trz_pkg::ST_EDGE_SUB: state_in = trz_pkg::ST_DEPTH_MUL;
         trz_pkg::ST_DEPTH_MUL: begin
            state_in = covered ? trz_pkg::ST_SUM : trz_pkg::ST_WRITE;
         end
         trz_pkg::ST_SUM:   state_in = trz_pkg::ST_ROUND;
         trz_pkg::ST_ROUND: state_in = trz_pkg::ST_SAT;
         trz_pkg::ST_SAT: begin
            state_in = sat ? trz_pkg::ST_WRITE : trz_pkg::ST_DIV;
         end
         trz_pkg::ST_DIV: begin
            if (div_last) state_in = trz_pkg::ST_WRITE;
         end
         trz_pkg::ST_WRITE: begin
            state_in         = trz_pkg::ST_IDLE;
            mem_we           = wr;
            rsp_valid_in     = 1'b1;
            rsp_in.pix_x     = trz_pkg::PIX_W'(job_ff.x);
            rsp_in.pix_y     = trz_pkg::PIX_W'(job_ff.y);
            rsp_in.pix_color = wr ? tri_ff.tri_color : '0;
            rsp_in.pix_write = wr;
            rsp_in.scan_done = job_ff.last;
         end
         default: state_in = trz_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trz_pkg::ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (task_pop) begin
            cnt_ff <= '0;
         end else if (state_ff == trz_pkg::ST_INIT || state_ff == trz_pkg::ST_CLEAR) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (task_pop) begin
         job_ff <= task_data;
         if (task_data.job == trz_pkg::JOB_LOAD) tri_ff <= task_data.req;
      end
      for (int i = 0; i < 6; i++) begin
         prod_ff[i] <= opa[i] * opb[i];
      end
      case (state_ff)
         trz_pkg::ST_AREA_SUB: begin
            area_ff <= trz_pkg::EDGE_W'(prod_ff[0]) - trz_pkg::EDGE_W'(prod_ff[1]);
         end
         trz_pkg::ST_EDGE_MUL: begin
            addr_ff <= trz_pkg::ADDR_W'(row * dims.w) + trz_pkg::ADDR_W'(job_ff.x);
         end
         trz_pkg::ST_EDGE_SUB: begin
            for (int k = 0; k < 3; k++) begin
               edge_ff[k] <= trz_pkg::EDGE_W'(prod_ff[2*k]) -
                             trz_pkg::EDGE_W'(prod_ff[2*k+1]);
            end
         end
         trz_pkg::ST_DEPTH_MUL: begin
            ok_ff     <= covered;
            mul_ff[0] <= trz_pkg::MUL_W'(edge_ff[1][trz_pkg::EDGE_W-2:0]) *
                         trz_pkg::MUL_W'(tri_ff.adepth);
            mul_ff[1] <= trz_pkg::MUL_W'(edge_ff[2][trz_pkg::EDGE_W-2:0]) *
                         trz_pkg::MUL_W'(tri_ff.bdepth);
            mul_ff[2] <= trz_pkg::MUL_W'(edge_ff[0][trz_pkg::EDGE_W-2:0]) *
                         trz_pkg::MUL_W'(tri_ff.cdepth);
         end
         trz_pkg::ST_SUM: begin
            num_ff <= trz_pkg::REM_W'(mul_ff[0]) + trz_pkg::REM_W'(mul_ff[1]) +
                      trz_pkg::REM_W'(mul_ff[2]);
         end
         trz_pkg::ST_ROUND: begin
            rem_ff <= num_ff + trz_pkg::REM_W'(area_u >> 1);
         end
         trz_pkg::ST_SAT: begin
            quo_ff <= sat ? trz_pkg::FAR_DEPTH : '0;
            dsh_ff <= trz_pkg::REM_W'(area_u) << (trz_pkg::DEPTH_BITS - 1);
            bit_ff <= '0;
         end
         trz_pkg::ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_ff <= rem_ff - dsh_ff;
               quo_ff <= {quo_ff[trz_pkg::DEPTH_BITS-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[trz_pkg::DEPTH_BITS-2:0], 1'b0};
            end
            dsh_ff <= dsh_ff >> 1;
            bit_ff <= bit_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign init_busy  = (state_ff == trz_pkg::ST_INIT);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trz_pkg::ST_INIT) |-> !rsp_valid_ff)
      else $error("result during depth store init");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == trz_pkg::ST_DIV) |=>
      (state_ff == trz_pkg::ST_DIV || state_ff == trz_pkg::ST_WRITE))
      else $error("divider left early");
   a_write_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pix_write) |-> ($past(state_ff) == trz_pkg::ST_WRITE))
      else $error("pixel write outside write state");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      task_pop |-> (state_ff == trz_pkg::ST_IDLE && !task_empty))
      else $error("task pop while back busy");
`endif

endmodule
`default_nettype wire

// ===== design/triangle_raster_zbuffer.sv =====
// Triangle rasterizer with depth store. From idle, a step with no box or an unused code answers
// from idle; a load runs area multiply and subtract; a step outside triangle or screen runs edge
// multiply, edge subtract and depth multiply; a saturated depth adds sum, round and saturate; a
// divided depth adds the divider (one quotient bit per cycle); a clear walks the whole store.
// The back end takes the next queued item once idle again; two wait. After reset busy stays high
// while the depth store is set to the far value; rsp_strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module triangle_raster_zbuffer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire trz_pkg::req_type            req_data,
   output logic                             rsp_strobe,
   output trz_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [trz_pkg::CFG_W-1:0]   csr_wdata
);

   logic [trz_pkg::CFG_W-1:0] width_ff, height_ff;
   trz_pkg::dims_type         dims;
   trz_pkg::task_type         push_data, pop_data;
   logic                      accept, push, pop, empty, full, init_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= trz_pkg::CFG_W'(512);
         height_ff <= trz_pkg::CFG_W'(512);
      end else if (csr_we) begin
         if (csr_index == 1'b0) begin
            width_ff <= csr_wdata;
         end else begin
            height_ff <= csr_wdata;
         end
      end
   end

   assign dims.w = trz_pkg::eff_dim(width_ff, trz_pkg::DIM_W'(trz_pkg::MAX_WIDTH));
   assign dims.h = trz_pkg::eff_dim(height_ff, trz_pkg::DIM_W'(trz_pkg::MAX_HEIGHT));
   assign busy   = full || init_busy;
   assign accept = start && !busy;

   trz_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .dims      (dims),
      .push      (push),
      .push_data (push_data)
   );

   trz_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty),
      .full      (full)
   );

   trz_back u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims),
      .task_data  (pop_data),
      .task_empty (empty),
      .task_pop   (pop),
      .init_busy  (init_busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
